>>> sv/lcs_pkg.sv
// Shared constants and types of the longest common subsequence block.
// Used by the channel interfaces and the top level; depends on nothing.
package lcs_pkg;

    localparam int MAX_LEN = 32;
    localparam int SymW    = 8;
    localparam int ReqW    = 2;
    localparam int OutLenW = 6;
    localparam int LenW    = $clog2(MAX_LEN + 1);
    localparam int IdxW    = $clog2(MAX_LEN);
    localparam int AddrW   = 2 * IdxW;

    typedef enum logic [ReqW-1:0] {
        REQ_FIRST  = 2'd0,
        REQ_SECOND = 2'd1,
        REQ_RUN    = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW,
        S_CELL,
        S_DRAIN,
        S_LEN,
        S_LEN_WAIT,
        S_TB_RD,
        S_TB_CMP,
        S_TB_LEFT,
        S_EMIT_RD,
        S_EMIT_LD,
        S_MARK
    } t_state;

endpackage

>>> sv/lcs_req_if.sv
// Request channel of the longest common subsequence block.
// Depends on lcs_pkg for the field widths.
interface lcs_req_if;
    logic                      valid;
    logic                      ready;
    logic [lcs_pkg::ReqW-1:0]  req_type;
    logic [lcs_pkg::SymW-1:0]  symbol;

    modport source (output valid, output req_type, output symbol, input ready);
    modport sink   (input valid, input req_type, input symbol, output ready);
endinterface

>>> sv/lcs_res_if.sv
// Result channel of the longest common subsequence block.
// Depends on lcs_pkg for the field widths.
interface lcs_res_if;
    logic                         valid;
    logic                         ready;
    logic [lcs_pkg::SymW-1:0]     lcs_symbol;
    logic [lcs_pkg::OutLenW-1:0]  lcs_length;
    logic                         symbol_valid;
    logic                         last_symbol;
    logic                         overflow;

    modport source (output valid, output lcs_symbol, output lcs_length,
                    output symbol_valid, output last_symbol, output overflow,
                    input ready);
    modport sink   (input valid, input lcs_symbol, input lcs_length,
                    input symbol_valid, input last_symbol, input overflow,
                    output ready);
endinterface

>>> sv/longest_common_subsequence.sv
// Longest common subsequence: string, score table and answer memories with a sequencer.
// Depends on lcs_pkg, lcs_req_if and lcs_res_if.
// An append beat is taken in the idle state. A run with strings of m and n symbols fills the
// score table at one score cell per cycle within a row, after a row-start read of each row,
// traces back (read, compare, left read on mismatch), then reads and sends each result beat.
// Reset clears the counts, the dropped flag and the handshake state; memories are not cleared.
module longest_common_subsequence (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lcs_req_if.sink   i_req,
    lcs_res_if.source o_res
);

    localparam int SymW    = lcs_pkg::SymW;
    localparam int LenW    = lcs_pkg::LenW;
    localparam int IdxW    = lcs_pkg::IdxW;
    localparam int AddrW   = lcs_pkg::AddrW;
    localparam int OutLenW = lcs_pkg::OutLenW;
    localparam int Depth   = lcs_pkg::MAX_LEN * lcs_pkg::MAX_LEN;

    logic [SymW-1:0] mem_a   [lcs_pkg::MAX_LEN];
    logic [SymW-1:0] mem_b   [lcs_pkg::MAX_LEN];
    logic [LenW-1:0] mem_s   [Depth];
    logic [SymW-1:0] mem_ans [lcs_pkg::MAX_LEN];

    logic [SymW-1:0] r_a_rd, r_b_rd, r_ans_rd;
    logic [LenW-1:0] r_s_rd;

    logic             a_we, a_re, b_we, b_re, s_we, s_re, ans_we, ans_re;
    logic [IdxW-1:0]  a_wa, a_ra, b_wa, b_ra, ans_wa, ans_ra;
    logic [SymW-1:0]  a_wd, b_wd, ans_wd;
    logic [AddrW-1:0] s_wa, s_ra;
    logic [LenW-1:0]  s_wd;

    lcs_pkg::t_state r_state, n_state;
    lcs_pkg::t_req   req;

    logic [LenW-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic            r_dropped, n_dropped, r_ovf_job, n_ovf_job;
    logic [LenW-1:0] r_m, n_m, r_n, n_n;
    logic [IdxW-1:0] r_ci, n_ci, r_cj, n_cj;
    logic            r_pb, n_pb;
    logic [IdxW-1:0] r_pb_i, n_pb_i, r_pb_j, n_pb_j;
    logic [LenW-1:0] r_left, n_left, r_diag, n_diag;
    logic [LenW-1:0] r_ti, n_ti, r_tj, n_tj, r_k, n_k, r_len, n_len, r_oi, n_oi;
    logic [LenW-1:0] r_up, n_up;
    logic            r_up_zero, n_up_zero, r_left_zero, n_left_zero;

    logic               r_out_valid, n_out_valid;
    logic [SymW-1:0]    r_out_sym, n_out_sym;
    logic [OutLenW-1:0] r_out_len, n_out_len;
    logic               r_out_symv, n_out_symv, r_out_last, n_out_last, r_out_ovf, n_out_ovf;

    logic [LenW-1:0] st_up, st_left, st_diag, st_cell, tb_left;
    logic            out_free, emit_last;

    assign req = lcs_pkg::t_req'(i_req.req_type);

    assign i_req.ready        = (r_state == lcs_pkg::S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.lcs_symbol   = r_out_sym;
    assign o_res.lcs_length   = r_out_len;
    assign o_res.symbol_valid = r_out_symv;
    assign o_res.last_symbol  = r_out_last;
    assign o_res.overflow     = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (a_we) mem_a[a_wa] <= a_wd;
        if (a_re) r_a_rd <= mem_a[a_ra];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) mem_b[b_wa] <= b_wd;
        if (b_re) r_b_rd <= mem_b[b_ra];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) mem_s[s_wa] <= s_wd;
        if (s_re) r_s_rd <= mem_s[s_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ans_we) mem_ans[ans_wa] <= ans_wd;
        if (ans_re) r_ans_rd <= mem_ans[ans_ra];
    end

    always_comb begin
        st_up   = (r_pb_i == '0) ? '0 : r_s_rd;
        st_left = (r_pb_j == '0) ? '0 : r_left;
        st_diag = (r_pb_i == '0 || r_pb_j == '0) ? '0 : r_diag;
        if (r_a_rd == r_b_rd) begin
            st_cell = st_diag + LenW'(1);
        end else begin
            st_cell = (st_up > st_left) ? st_up : st_left;
        end
        tb_left   = r_left_zero ? '0 : r_s_rd;
        out_free  = !r_out_valid || o_res.ready;
        emit_last = ((r_oi + LenW'(1)) == r_len);
    end

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_dropped   = r_dropped;
        n_ovf_job   = r_ovf_job;
        n_m         = r_m;
        n_n         = r_n;
        n_ci        = r_ci;
        n_cj        = r_cj;
        n_pb        = 1'b0;
        n_pb_i      = r_pb_i;
        n_pb_j      = r_pb_j;
        n_left      = r_left;
        n_diag      = r_diag;
        n_ti        = r_ti;
        n_tj        = r_tj;
        n_k         = r_k;
        n_len       = r_len;
        n_oi        = r_oi;
        n_up        = r_up;
        n_up_zero   = r_up_zero;
        n_left_zero = r_left_zero;
        n_out_valid = (r_out_valid && o_res.ready) ? 1'b0 : r_out_valid;
        n_out_sym   = r_out_sym;
        n_out_len   = r_out_len;
        n_out_symv  = r_out_symv;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        a_we = 1'b0; a_wa = '0; a_wd = i_req.symbol; a_re = 1'b0; a_ra = '0;
        b_we = 1'b0; b_wa = '0; b_wd = i_req.symbol; b_re = 1'b0; b_ra = '0;
        s_we = 1'b0; s_wa = '0; s_wd = st_cell;      s_re = 1'b0; s_ra = '0;
        ans_we = 1'b0; ans_wa = '0; ans_wd = r_a_rd; ans_re = 1'b0; ans_ra = '0;

        // The cell issued in the previous cycle is finished and written back here.
        if (r_pb) begin
            s_we   = 1'b1;
            s_wa   = {r_pb_i, r_pb_j};
            n_left = st_cell;
            n_diag = st_up;
        end

        case (r_state)
            lcs_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    case (req)
                        lcs_pkg::REQ_FIRST: begin
                            if (r_cnt_a < LenW'(lcs_pkg::MAX_LEN)) begin
                                a_we    = 1'b1;
                                a_wa    = IdxW'(r_cnt_a);
                                n_cnt_a = r_cnt_a + LenW'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        lcs_pkg::REQ_SECOND: begin
                            if (r_cnt_b < LenW'(lcs_pkg::MAX_LEN)) begin
                                b_we    = 1'b1;
                                b_wa    = IdxW'(r_cnt_b);
                                n_cnt_b = r_cnt_b + LenW'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        lcs_pkg::REQ_RUN: begin
                            n_m       = r_cnt_a;
                            n_n       = r_cnt_b;
                            n_ovf_job = r_dropped;
                            n_cnt_a   = '0;
                            n_cnt_b   = '0;
                            n_dropped = 1'b0;
                            n_ci      = '0;
                            n_cj      = '0;
                            if (r_cnt_a == '0 || r_cnt_b == '0) begin
                                n_state = lcs_pkg::S_MARK;
                            end else begin
                                n_state = lcs_pkg::S_ROW;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lcs_pkg::S_ROW: begin
                a_re    = 1'b1;
                a_ra    = r_ci;
                n_state = lcs_pkg::S_CELL;
            end
            lcs_pkg::S_CELL: begin
                b_re   = 1'b1;
                b_ra   = r_cj;
                s_re   = 1'b1;
                s_ra   = {IdxW'(r_ci - IdxW'(1)), r_cj};
                n_pb   = 1'b1;
                n_pb_i = r_ci;
                n_pb_j = r_cj;
                if (LenW'(r_cj) == r_n - LenW'(1)) begin
                    n_cj = '0;
                    if (LenW'(r_ci) == r_m - LenW'(1)) begin
                        n_state = lcs_pkg::S_DRAIN;
                    end else begin
                        n_ci    = r_ci + IdxW'(1);
                        n_state = lcs_pkg::S_ROW;
                    end
                end else begin
                    n_cj = r_cj + IdxW'(1);
                end
            end
            lcs_pkg::S_DRAIN: begin
                n_state = lcs_pkg::S_LEN;
            end
            lcs_pkg::S_LEN: begin
                s_re    = 1'b1;
                s_ra    = {IdxW'(r_m - LenW'(1)), IdxW'(r_n - LenW'(1))};
                n_ti    = r_m;
                n_tj    = r_n;
                n_state = lcs_pkg::S_LEN_WAIT;
            end
            lcs_pkg::S_LEN_WAIT: begin
                n_len = r_s_rd;
                n_k   = r_s_rd;
                if (r_s_rd == '0) begin
                    n_state = lcs_pkg::S_MARK;
                end else begin
                    n_state = lcs_pkg::S_TB_RD;
                end
            end
            lcs_pkg::S_TB_RD: begin
                if (r_ti == '0 || r_tj == '0) begin
                    n_oi    = '0;
                    n_state = lcs_pkg::S_EMIT_RD;
                end else begin
                    a_re      = 1'b1;
                    a_ra      = IdxW'(r_ti - LenW'(1));
                    b_re      = 1'b1;
                    b_ra      = IdxW'(r_tj - LenW'(1));
                    s_re      = 1'b1;
                    s_ra      = {IdxW'(r_ti - LenW'(2)), IdxW'(r_tj - LenW'(1))};
                    n_up_zero = (r_ti < LenW'(2));
                    n_state   = lcs_pkg::S_TB_CMP;
                end
            end
            lcs_pkg::S_TB_CMP: begin
                if (r_a_rd == r_b_rd) begin
                    if (r_k != '0) begin
                        ans_we = 1'b1;
                        ans_wa = IdxW'(r_k - LenW'(1));
                        n_k    = r_k - LenW'(1);
                    end
                    n_ti    = r_ti - LenW'(1);
                    n_tj    = r_tj - LenW'(1);
                    n_state = lcs_pkg::S_TB_RD;
                end else begin
                    n_up        = r_up_zero ? '0 : r_s_rd;
                    s_re        = 1'b1;
                    s_ra        = {IdxW'(r_ti - LenW'(1)), IdxW'(r_tj - LenW'(2))};
                    n_left_zero = (r_tj < LenW'(2));
                    n_state     = lcs_pkg::S_TB_LEFT;
                end
            end
            lcs_pkg::S_TB_LEFT: begin
                if (r_up > tb_left) begin
                    n_ti = r_ti - LenW'(1);
                end else begin
                    n_tj = r_tj - LenW'(1);
                end
                n_state = lcs_pkg::S_TB_RD;
            end
            lcs_pkg::S_EMIT_RD: begin
                ans_re  = 1'b1;
                ans_ra  = IdxW'(r_oi);
                n_state = lcs_pkg::S_EMIT_LD;
            end
            lcs_pkg::S_EMIT_LD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sym   = r_ans_rd;
                    n_out_len   = OutLenW'(r_len);
                    n_out_symv  = 1'b1;
                    n_out_last  = emit_last;
                    n_out_ovf   = r_ovf_job;
                    n_oi        = r_oi + LenW'(1);
                    n_state     = emit_last ? lcs_pkg::S_IDLE : lcs_pkg::S_EMIT_RD;
                end
            end
            lcs_pkg::S_MARK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sym   = '0;
                    n_out_len   = '0;
                    n_out_symv  = 1'b0;
                    n_out_last  = 1'b1;
                    n_out_ovf   = r_ovf_job;
                    n_state     = lcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lcs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcs_pkg::S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_dropped   <= 1'b0;
            r_pb        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_dropped   <= n_dropped;
            r_pb        <= n_pb;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovf_job   <= n_ovf_job;
        r_m         <= n_m;
        r_n         <= n_n;
        r_ci        <= n_ci;
        r_cj        <= n_cj;
        r_pb_i      <= n_pb_i;
        r_pb_j      <= n_pb_j;
        r_left      <= n_left;
        r_diag      <= n_diag;
        r_ti        <= n_ti;
        r_tj        <= n_tj;
        r_k         <= n_k;
        r_len       <= n_len;
        r_oi        <= n_oi;
        r_up        <= n_up;
        r_up_zero   <= n_up_zero;
        r_left_zero <= n_left_zero;
        r_out_sym   <= n_out_sym;
        r_out_len   <= n_out_len;
        r_out_symv  <= n_out_symv;
        r_out_last  <= n_out_last;
        r_out_ovf   <= n_out_ovf;
    end

endmodule
